[design/box_average_downsampler_defines.svh]
// Assertion macros for the box average downsampler.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH

// Checks that a property holds at every clock edge outside of reset.
`define BOXAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge outside of reset.
`define BOXAVG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/boxavg_pkg.sv]
// Shared constants, types and the reciprocal table of the box average downsampler.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package boxavg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_FACTOR = 16;
  localparam int ROW_LIMIT  = 1024;

  localparam int PIX_W    = 8;
  localparam int FACTOR_W = 5;
  localparam int SIZE_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W    = 10;
  localparam int INB_W    = 4;
  localparam int SUM_W    = 16;
  localparam int AREA_W   = 2 * FACTOR_W;
  localparam int DIVN_W   = SUM_W + 1;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W  = RECIP_SHIFT + 1;
  localparam int PROD_W   = DIVN_W + RECIP_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
  localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 11'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a pixel, read its column sum, advance the raster counters
    logic accum;     // add the pixel, write back the column sum of a whole block, form the dividend
    logic mult;      // multiply the dividend by the reciprocal of the block area
    logic load_out;  // move the mean into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the pixel in flight completes a block
    logic out_free;  // the output register can take a new result this cycle
  } status_t;

  // Ceiling of 2^25 over f*f. For a dividend below 2^17 the top bits of the
  // product give the exact floor quotient.
  function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    begin
      unique case (f)
        5'd1:    r = 26'd33554432;
        5'd2:    r = 26'd8388608;
        5'd3:    r = 26'd3728271;
        5'd4:    r = 26'd2097152;
        5'd5:    r = 26'd1342178;
        5'd6:    r = 26'd932068;
        5'd7:    r = 26'd684785;
        5'd8:    r = 26'd524288;
        5'd9:    r = 26'd414253;
        5'd10:   r = 26'd335545;
        5'd11:   r = 26'd277310;
        5'd12:   r = 26'd233017;
        5'd13:   r = 26'd198547;
        5'd14:   r = 26'd171197;
        5'd15:   r = 26'd149131;
        5'd16:   r = 26'd131072;
        default: r = 26'd131072;
      endcase
      return r;
    end
  endfunction

endpackage

[design/box_average_downsampler.sv]
// Box average downsampler: a pixel without a result frees the input after the
// accumulate state; a pixel that completes a block passes the accumulate, multiply and
// emit states, and the emit state, which waits while dst_stall holds an earlier result,
// loads its mean into the output register and frees the input. No new pixel is taken
// before the last one is through. Synchronous reset clears the raster counters and the
// handshake state and loads the registers with factor 2 and a 1024 by 1024 image.
`timescale 1ns / 1ps
`include "box_average_downsampler_defines.svh"

module box_average_downsampler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [boxavg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                             src_valid,
  output logic                             src_stall,
  input  logic [boxavg_pkg::PIX_W-1:0]     pixel_in,
  output logic                             dst_valid,
  input  logic                             dst_stall,
  output logic [boxavg_pkg::PIX_W-1:0]     pixel_out,
  output logic                             frame_last
);

  boxavg_pkg::cmd_t    cmd;
  boxavg_pkg::status_t status;

  boxavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .status    (status),
    .cmd       (cmd)
  );

  boxavg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_in),
    .cmd        (cmd),
    .status     (status),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  // The block works on one pixel at a time.
  `BOXAVG_ASSERT(a_busy_after_transfer, (src_valid && !src_stall) |=> src_stall, "pixel taken while busy")
  // A result must never overwrite one that is still held by the receiver.
  `BOXAVG_NEVER(a_no_overwrite, cmd.load_out && dst_valid && dst_stall, "output overwritten")
  `BOXAVG_ASSERT(a_valid_from_load, $rose(dst_valid) |-> $past(cmd.load_out), "result without load")
  `BOXAVG_ASSERT(a_mult_after_accum, cmd.mult |-> $past(cmd.accum), "multiply out of order")

endmodule

[design/boxavg_ctrl.sv]
// Controller state machine of the box average downsampler.
// Depends on boxavg_pkg for the command and status types.
`timescale 1ns / 1ps

module boxavg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  boxavg_pkg::status_t status,
  output boxavg_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ACCUM = 4'b0010,
    ST_MULT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign src_stall = rst || (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (src_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.emit ? ST_MULT : ST_IDLE;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Wait here until the previous result has been transferred.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/boxavg_dp.sv]
// Datapath of the box average downsampler: configuration registers, raster
// counters, column-sum memory, reciprocal multiplier and output register.
// Depends on boxavg_pkg for widths, register indexes, types and the reciprocal table.
`timescale 1ns / 1ps

module boxavg_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [boxavg_pkg::CFG_W-1:0]           cfg_data,
  input  logic [boxavg_pkg::PIX_W-1:0]           pixel_in,
  input  boxavg_pkg::cmd_t                       cmd,
  output boxavg_pkg::status_t                    status,
  output logic                                   dst_valid,
  input  logic                                   dst_stall,
  output logic [boxavg_pkg::PIX_W-1:0]           pixel_out,
  output logic                                   frame_last
);

  // Configuration registers and their clamped values.
  logic [boxavg_pkg::FACTOR_W-1:0] factor_reg;
  logic [boxavg_pkg::SIZE_W-1:0]   width_reg;
  logic [boxavg_pkg::SIZE_W-1:0]   height_reg;
  logic [boxavg_pkg::FACTOR_W-1:0] f;
  logic [boxavg_pkg::SIZE_W-1:0]   w;
  logic [boxavg_pkg::SIZE_W-1:0]   h;
  logic [boxavg_pkg::INB_W-1:0]    fm1;
  logic                            restart;

  // Raster position.
  logic [boxavg_pkg::CNT_W-1:0] col_count;
  logic [boxavg_pkg::CNT_W-1:0] row_count;
  logic [boxavg_pkg::INB_W-1:0] col_in_block;
  logic [boxavg_pkg::INB_W-1:0] row_in_block;
  logic [boxavg_pkg::IDX_W-1:0] block_col;

  logic [boxavg_pkg::CNT_W-1:0] col_start;
  logic [boxavg_pkg::CNT_W-1:0] row_start;
  logic                         col_full;
  logic                         row_full;
  logic                         col_end;
  logic                         row_end;
  logic                         cib_wrap;
  logic                         rib_wrap;
  logic                         block_first;
  logic                         block_last;
  logic                         last_col_block;
  logic                         last_row_block;

  // Pixel in flight.
  logic [boxavg_pkg::PIX_W-1:0]   pix_q;
  logic                           first_q;
  logic                           write_q;
  logic                           emit_q;
  logic                           last_q;
  logic [boxavg_pkg::IDX_W-1:0]   idx_q;

  logic [boxavg_pkg::SUM_W-1:0]   sums [boxavg_pkg::MAX_WIDTH];
  logic [boxavg_pkg::SUM_W-1:0]   rdata;
  logic [boxavg_pkg::SUM_W-1:0]   sum;
  logic [boxavg_pkg::AREA_W-1:0]  area;
  logic [boxavg_pkg::DIVN_W-1:0]  div_n;
  logic [boxavg_pkg::RECIP_W-1:0] recip_q;
  logic [boxavg_pkg::PROD_W-1:0]  prod;

  always_comb begin
    if (factor_reg == '0) begin
      f = boxavg_pkg::FACTOR_W'(1);
    end else if (factor_reg > boxavg_pkg::FACTOR_W'(boxavg_pkg::MAX_FACTOR)) begin
      f = boxavg_pkg::FACTOR_W'(boxavg_pkg::MAX_FACTOR);
    end else begin
      f = factor_reg;
    end
    if (width_reg == '0) begin
      w = boxavg_pkg::SIZE_W'(1);
    end else if (width_reg > boxavg_pkg::SIZE_W'(boxavg_pkg::MAX_WIDTH)) begin
      w = boxavg_pkg::SIZE_W'(boxavg_pkg::MAX_WIDTH);
    end else begin
      w = width_reg;
    end
    if (height_reg == '0) begin
      h = boxavg_pkg::SIZE_W'(1);
    end else if (height_reg > boxavg_pkg::SIZE_W'(boxavg_pkg::ROW_LIMIT)) begin
      h = boxavg_pkg::SIZE_W'(boxavg_pkg::ROW_LIMIT);
    end else begin
      h = height_reg;
    end
  end

  assign fm1     = boxavg_pkg::INB_W'(f - boxavg_pkg::FACTOR_W'(1));
  assign restart = cfg_write && (cfg_index == boxavg_pkg::REG_BLOCK_FACTOR ||
                                 cfg_index == boxavg_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == boxavg_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg <= boxavg_pkg::FACTOR_RESET;
      width_reg  <= boxavg_pkg::WIDTH_RESET;
      height_reg <= boxavg_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        boxavg_pkg::REG_BLOCK_FACTOR: factor_reg <= cfg_data[boxavg_pkg::FACTOR_W-1:0];
        boxavg_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        boxavg_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // A pixel lies in a whole block when the block it belongs to ends inside
  // the image, in both directions.
  assign col_start = col_count - boxavg_pkg::CNT_W'(col_in_block);
  assign row_start = row_count - boxavg_pkg::CNT_W'(row_in_block);
  assign col_full  = ({2'b00, col_start} + 12'(f)) <= {1'b0, w};
  assign row_full  = ({2'b00, row_start} + 12'(f)) <= {1'b0, h};
  assign col_end   = ({1'b0, col_count} + 11'd1) >= w;
  assign row_end   = ({1'b0, row_count} + 11'd1) >= h;
  assign cib_wrap  = col_in_block == fm1;
  assign rib_wrap  = row_in_block == fm1;
  assign block_first = (col_in_block == '0) && (row_in_block == '0);
  assign block_last  = cib_wrap && rib_wrap;
  // At the last pixel of a block, no further whole block fits to the right or below.
  assign last_col_block = ({2'b00, col_count} + 12'd1 + 12'(f)) > {1'b0, w};
  assign last_row_block = ({2'b00, row_count} + 12'd1 + 12'(f)) > {1'b0, h};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count    <= '0;
      row_count    <= '0;
      col_in_block <= '0;
      row_in_block <= '0;
      block_col    <= '0;
    end else if (cmd.accept) begin
      if (col_end) begin
        col_count    <= '0;
        col_in_block <= '0;
        block_col    <= '0;
        if (row_end) begin
          row_count    <= '0;
          row_in_block <= '0;
        end else begin
          row_count    <= row_count + boxavg_pkg::CNT_W'(1);
          row_in_block <= rib_wrap ? '0 : row_in_block + boxavg_pkg::INB_W'(1);
        end
      end else begin
        col_count    <= col_count + boxavg_pkg::CNT_W'(1);
        col_in_block <= cib_wrap ? '0 : col_in_block + boxavg_pkg::INB_W'(1);
        block_col    <= cib_wrap ? block_col + boxavg_pkg::IDX_W'(1) : block_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_q   <= pixel_in;
      first_q <= block_first;
      write_q <= col_full && row_full;
      last_q  <= last_col_block && last_row_block;
      idx_q   <= block_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else if (cmd.accept) begin
      emit_q <= col_full && row_full && block_last;
    end
  end

  assign status.emit = emit_q;

  // Column-sum memory: read when a pixel is taken, written back in the next cycle for a pixel of a whole block.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata <= sums[block_col];
    end
    if (cmd.accum && write_q) begin
      sums[idx_q] <= sum;
    end
  end

  // The first pixel of a block starts a fresh sum, so no stale entry is used.
  assign sum  = first_q ? boxavg_pkg::SUM_W'(pix_q) : rdata + boxavg_pkg::SUM_W'(pix_q);
  assign area = boxavg_pkg::AREA_W'(f) * boxavg_pkg::AREA_W'(f);

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      div_n   <= {1'b0, sum} + boxavg_pkg::DIVN_W'(area[boxavg_pkg::AREA_W-1:1]);
      recip_q <= boxavg_pkg::recip(f);
    end
    if (cmd.mult) begin
      prod <= boxavg_pkg::PROD_W'(div_n) * boxavg_pkg::PROD_W'(recip_q);
    end
  end

  assign status.out_free = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.load_out) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_out  <= prod[boxavg_pkg::RECIP_SHIFT +: boxavg_pkg::PIX_W];
      frame_last <= last_q;
    end
  end

endmodule
